>>> hw/rtl/scfp_pkg.sv
// Shared types, codes and helpers for the scale command frame parser.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package scfp_pkg;

  localparam logic [7:0] HDR_BYTE    = 8'h22;
  localparam logic [7:0] CMD_READ    = 8'h30;
  localparam logic [7:0] CMD_CONTROL = 8'h66;
  localparam logic [7:0] FILL_BYTE   = 8'hFF;

  localparam logic [2:0] TGT_SCALE_ONE = 3'd0;
  localparam logic [2:0] TGT_SCALE_TWO = 3'd1;
  localparam logic [2:0] TGT_LIMITS    = 3'd2;
  localparam logic [2:0] TGT_SPIN      = 3'd3;
  localparam logic [2:0] TGT_PUSH      = 3'd4;

  // Job queue between parser and emitter
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam int unsigned FrameLen = 8;
  localparam int unsigned IdxW     = $clog2(FrameLen);
  localparam logic [IdxW-1:0] LAST_IDX = IdxW'(FrameLen - 1);

  typedef enum logic [1:0] {
    KIND_RESPONSE = 2'd0,
    KIND_SPIN     = 2'd1,
    KIND_PUSH     = 2'd2
  } result_kind_e;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_COMMAND = 3'd1,
    PH_TARGET  = 3'd2,
    PH_DATA    = 3'd3,
    PH_FINAL   = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [31:0] scale_one_count;
    logic [31:0] scale_two_count;
    logic [5:0]  limit_bits;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  tx_byte;
    logic        frame_last;
    logic [15:0] move_length;
  } out_item_t;

  // One unit of work for the emitter: a reply frame or a move command.
  // For frames, word holds the counter or the zero-extended limit bits;
  // for moves, word[15:0] holds the length.
  typedef struct packed {
    logic         is_frame;
    result_kind_e kind;
    logic [2:0]   target;
    logic [31:0]  word;
  } job_t;

  function automatic logic [7:0] frame_byte(job_t job, logic [IdxW-1:0] idx);
    logic [7:0] b;
    logic       lim;
    lim = (job.target == TGT_LIMITS);
    case (idx)
      3'd0:    b = HDR_BYTE;
      3'd1:    b = CMD_READ;
      3'd2:    b = {5'd0, job.target};
      3'd3:    b = job.word[7:0];
      3'd4:    b = lim ? FILL_BYTE : job.word[15:8];
      3'd5:    b = lim ? FILL_BYTE : job.word[23:16];
      3'd6:    b = lim ? FILL_BYTE : job.word[31:24];
      default: b = FILL_BYTE;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/scale_command_frame_parser_unit.sv
// Scale command frame parser. One command byte is accepted per cycle while the
// two-entry job queue has room; a read request (targets 0..2) turns into an
// eight-byte reply frame and a spin/push request into one command result. The
// emitter puts out one result per cycle while the output is not stalled, so a
// reply frame of eight results, longer than the five-byte read request that
// causes it, sets the sustained rate. The byte that causes a job is written into
// the job queue, and the job's first result then into the output register; a
// stalled output holds it in the queue. Counters and limit bits are sampled with
// the data byte. No clearing pass after reset.
// Depends on scfp_pkg, scfp_front, scfp_queue, scfp_back.
`default_nettype none

module scale_command_frame_parser_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire scfp_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output scfp_pkg::out_item_t      out_item_o
);
  import scfp_pkg::*;

  logic job_push, job_room, head_valid, head_pop;
  job_t push_job, head_job;

  scfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .job_valid_o (job_push),
    .job_ready_i (job_room),
    .job_o       (push_job)
  );

  scfp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (job_push),
    .push_ready_o (job_room),
    .push_job_i   (push_job),
    .pop_valid_o  (head_valid),
    .pop_i        (head_pop),
    .pop_job_o    (head_job)
  );

  scfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_pop_o   (head_pop),
    .job_i       (head_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/scfp_front.sv
// Frame parser: accepts command bytes, tracks the frame phase and posts jobs.
// Depends on scfp_pkg.
`default_nettype none

module scfp_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire scfp_pkg::in_item_t in_item_i,
  output logic                  job_valid_o,
  input  wire logic             job_ready_i,
  output scfp_pkg::job_t        job_o
);
  import scfp_pkg::*;

  phase_e     phase_q, phase_d;
  logic [2:0] target_q, target_d;
  logic [7:0] low_q, low_d;
  logic       accept;
  logic [7:0] ch;

  assign in_ready_o = job_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign ch         = in_item_i.rx_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      target_q <= TGT_SCALE_ONE;
      low_q    <= 8'd0;
    end else begin
      phase_q  <= phase_d;
      target_q <= target_d;
      low_q    <= low_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    target_d    = target_q;
    low_d       = low_q;
    job_valid_o = 1'b0;
    job_o       = '0;
    if (accept) begin
      case (phase_q)
        PH_COMMAND: begin
          phase_d = (ch == CMD_READ || ch == CMD_CONTROL) ? PH_TARGET : PH_HEADER;
        end
        PH_TARGET: begin
          if (ch inside {[8'd0:8'd4]}) begin
            target_d = ch[2:0];
            phase_d  = PH_DATA;
          end else begin
            phase_d = PH_HEADER;
          end
        end
        PH_DATA: begin
          low_d   = ch;
          phase_d = PH_FINAL;
          if (target_q inside {TGT_SCALE_ONE, TGT_SCALE_TWO, TGT_LIMITS}) begin
            job_valid_o     = 1'b1;
            job_o.is_frame  = 1'b1;
            job_o.kind      = KIND_RESPONSE;
            job_o.target    = target_q;
            if (target_q == TGT_LIMITS) begin
              job_o.word = {26'd0, in_item_i.limit_bits};
            end else if (target_q == TGT_SCALE_ONE) begin
              job_o.word = in_item_i.scale_one_count;
            end else begin
              job_o.word = in_item_i.scale_two_count;
            end
          end
        end
        PH_FINAL: begin
          phase_d = PH_HEADER;
          if (target_q inside {TGT_SPIN, TGT_PUSH}) begin
            job_valid_o    = 1'b1;
            job_o.is_frame = 1'b0;
            job_o.kind     = (target_q == TGT_SPIN) ? KIND_SPIN : KIND_PUSH;
            job_o.target   = target_q;
            job_o.word     = {16'd0, ch, low_q};
          end
        end
        default: begin
          phase_d = (ch == HDR_BYTE) ? PH_COMMAND : PH_HEADER;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/scfp_queue.sv
// Small register FIFO of jobs between the parser and the emitter.
// Depends on scfp_pkg (job_t, QDepth).
`default_nettype none

module scfp_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  output logic                push_ready_o,
  input  wire scfp_pkg::job_t push_job_i,
  output logic                pop_valid_o,
  input  wire logic           pop_i,
  output scfp_pkg::job_t      pop_job_o
);
  import scfp_pkg::*;

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != QCntW'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_job_o    = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  function automatic logic [QPtrW-1:0] bump(logic [QPtrW-1:0] p);
    return (p == QPtrW'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_d  = do_push ? bump(wr_q) : wr_q;
    rd_d  = do_pop ? bump(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/scfp_back.sv
// Emitter: walks the job at the queue head and drives the output register.
// Depends on scfp_pkg (job_t, out_item_t, frame_byte).
`default_nettype none

module scfp_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           job_valid_i,
  output logic                job_pop_o,
  input  wire scfp_pkg::job_t job_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output scfp_pkg::out_item_t out_item_o
);
  import scfp_pkg::*;

  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            load;
  logic            last;

  // Output register is free or drains this cycle
  assign load = job_valid_i && (!out_valid_q || out_ready_i);
  assign last = !job_i.is_frame || (idx_q == LAST_IDX);

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    idx_d       = idx_q;
    job_pop_o   = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      out_d       = '0;
      if (job_i.is_frame) begin
        out_d.result_kind = KIND_RESPONSE;
        out_d.tx_byte     = frame_byte(job_i, idx_q);
        out_d.frame_last  = (idx_q == LAST_IDX);
      end else begin
        out_d.result_kind = job_i.kind;
        out_d.move_length = job_i.word[15:0];
      end
      job_pop_o = last;
      idx_d     = last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/scfp_checker.sv
// Port-level checks for the scale command frame parser, bound to the top level.
// Depends on scfp_pkg.
`default_nettype none

module scfp_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire scfp_pkg::out_item_t out_item_o
);
  import scfp_pkg::*;

  // Output request holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output request dropped or changed while stalled");

  a_kind_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_item_o.result_kind == KIND_RESPONSE && out_item_o.move_length == 16'd0) ||
      ((out_item_o.result_kind == KIND_SPIN || out_item_o.result_kind == KIND_PUSH) &&
       out_item_o.tx_byte == 8'd0 && !out_item_o.frame_last))
    else $error("result fields do not match result kind");

  // A reply frame continues without interleaving once started
  a_frame_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_item_o.result_kind == KIND_RESPONSE &&
    !out_item_o.frame_last ##1 out_valid_o |->
      out_item_o.result_kind == KIND_RESPONSE)
    else $error("reply frame interrupted");

  a_frame_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_item_o.frame_last ##1
    out_valid_o && out_item_o.result_kind == KIND_RESPONSE |->
      out_item_o.tx_byte == HDR_BYTE)
    else $error("reply frame does not start with header");

endmodule

bind scale_command_frame_parser_unit scfp_checker u_scfp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
